FILE: hw/rtl/cld_pkg.sv
// shared types and constants for the canonical line discipline
`default_nettype none
package cld_pkg;

  localparam int CNT_W = 7;

  typedef enum logic [1:0] {
    OP_RECV  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_POP   = 2'd3
  } op_t;

  typedef enum logic {
    CFG_CANONICAL = 1'b0,
    CFG_ECHO      = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ECHO,
    ST_ACK,
    ST_POP,
    ST_READ
  } state_t;

  typedef struct packed {
    op_t              op;
    logic [7:0]       data_byte;
    logic [CNT_W-1:0] read_count;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       data_valid;
    logic       last;
  } out_item_t;

  localparam logic [7:0]  CH_BS     = 8'h08;
  localparam logic [7:0]  CH_LF     = 8'h0A;
  localparam logic [7:0]  CH_CR     = 8'h0D;
  localparam logic [7:0]  CH_DEL    = 8'h7F;
  localparam logic [7:0]  CH_MASK   = 8'h1F;
  localparam logic [7:0]  CH_INTR   = 8'h63 & CH_MASK;
  localparam logic [7:0]  CH_SPACE  = 8'h20;
  localparam logic [7:0]  CH_CARET  = 8'h5E;
  localparam logic [7:0]  CH_C      = 8'h43;
  localparam logic [15:0] LINES_MAX = 16'hFFFF;

endpackage
`default_nettype wire

FILE: hw/rtl/cld_ram.sv
// single write port, single registered read port ring storage
`default_nettype none
module cld_ram #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [7:0]        wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [7:0]        rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/canonical_line_discipline.sv
// top level of the canonical terminal line discipline
// usage:
//   in_* carries one transaction per operation: received byte, read, write
//   output byte or pop output byte. out_* returns result transactions; the
//   final one of each operation has last set. cfg_* writes canonical_mode
//   (index 0) and echo_enable (index 1); cfg_ready is always high.
// sequencing:
//   a received byte is echoed (up to 3 bytes) before its ack, a write output
//   byte is echoed before its ack, and a read with nothing readable or a pop
//   of an empty ring gives only an ack. a registered ring read lies between
//   accepting a pop and presenting its byte; a read streams one byte per
//   cycle while out_ready holds high, as the next entry is fetched while the
//   current one is presented. operations run one at a time; a new one is
//   taken once the previous one's last result sits in the output register.
// reset:
//   synchronous, active low. both rings empty, line counters zero, canonical
//   mode and echo on. ring contents are not cleared, so no clearing pass.
// stall:
//   the output register holds its transaction while out_ready is low and the
//   sequencer waits; nothing is dropped or repeated.
`default_nettype none
module canonical_line_discipline #(
  parameter int RING_DEPTH = 256,
  parameter int READ_MAX   = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire cld_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output cld_pkg::out_item_t       out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire cld_pkg::cfg_idx_t   cfg_index,
  input  wire logic                cfg_data
);

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int CNT_W = cld_pkg::CNT_W;

  function automatic logic [PTR_W-1:0] ring_inc(input logic [PTR_W-1:0] p);
    ring_inc = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ring_dec(input logic [PTR_W-1:0] p);
    ring_dec = (p == '0) ? PTR_W'(RING_DEPTH - 1) : p - PTR_W'(1);
  endfunction

  cld_pkg::state_t    state_r, state_nxt;
  logic               canon_r, echo_en_r;
  logic [PTR_W-1:0]   in_wp_r, in_wp_nxt;
  logic [PTR_W-1:0]   in_rp_r, in_rp_nxt;
  logic [PTR_W-1:0]   lb_r, lb_nxt;
  logic [PTR_W-1:0]   bcount_r, bcount_nxt;
  logic [15:0]        rlines_r, rlines_nxt;
  logic [PTR_W-1:0]   out_wp_r, out_wp_nxt;
  logic [PTR_W-1:0]   out_rp_r, out_rp_nxt;
  logic [7:0]         echo_q_r [3];
  logic [7:0]         echo_q_nxt [3];
  logic [1:0]         echo_n_r, echo_n_nxt;
  logic [CNT_W-1:0]   want_r, want_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic               out_valid_r, out_valid_nxt;
  cld_pkg::out_item_t out_data_r, out_data_nxt;

  // memory ports
  logic               in_wr_en, in_rd_en, out_wr_en, out_rd_en;
  logic [PTR_W-1:0]   in_rd_addr;
  logic [7:0]         in_rdata, out_rdata;

  // common conditions
  logic               in_acc, slot_free, emit;
  logic [7:0]         rx_c;
  logic               rx_erase, rx_intr, rx_room, rx_at_begin;
  logic [PTR_W:0]     rx_diff;
  logic [PTR_W-1:0]   rx_partial;
  logic [1:0]         rx_echo_n;
  logic [CNT_W-1:0]   rd_want;
  logic               rd_readable, in_empty, out_empty, out_room, rd_go;
  logic [PTR_W-1:0]   rd_rp_n, rd_bcount_dec;
  logic               rd_stop;

  assign in_ready  = (state_r == cld_pkg::ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // received byte decode
  assign rx_c        = (in_data.data_byte == cld_pkg::CH_CR) ? cld_pkg::CH_LF
                                                             : in_data.data_byte;
  assign rx_erase    = canon_r && (rx_c == cld_pkg::CH_BS || rx_c == cld_pkg::CH_DEL);
  assign rx_intr     = canon_r && (rx_c == cld_pkg::CH_INTR);
  assign rx_room     = (ring_inc(in_wp_r) != in_rp_r);
  assign rx_at_begin = (in_wp_r == lb_r);
  assign rx_diff     = {1'b0, in_wp_r} - {1'b0, lb_r};
  assign rx_partial  = rx_diff[PTR_W] ? PTR_W'(rx_diff + (PTR_W+1)'(RING_DEPTH))
                                      : rx_diff[PTR_W-1:0];

  always_comb begin
    rx_echo_n = 2'd0;
    if (echo_en_r) begin
      if (rx_erase) begin
        rx_echo_n = rx_at_begin ? 2'd0 : 2'd3;
      end else if (rx_intr) begin
        rx_echo_n = 2'd3;
      end else if (rx_room) begin
        rx_echo_n = 2'd1;
      end
    end
  end

  // read setup and per-byte stop
  assign rd_want     = (in_data.read_count > CNT_W'(READ_MAX)) ? CNT_W'(READ_MAX)
                                                               : in_data.read_count;
  assign rd_readable = (rlines_r != 16'd0) || (bcount_r != '0 && !canon_r);
  assign in_empty    = (in_rp_r == in_wp_r);
  assign rd_go       = rd_readable && (rd_want != '0) && !in_empty;
  assign rd_rp_n     = ring_inc(in_rp_r);
  assign rd_bcount_dec = (bcount_r != '0) ? bcount_r - PTR_W'(1) : bcount_r;
  assign rd_stop     = ((n_r + CNT_W'(1)) == want_r) || (rd_rp_n == in_wp_r) ||
                       (canon_r && in_rdata == cld_pkg::CH_LF);

  assign out_empty = (out_rp_r == out_wp_r);
  assign out_room  = (ring_inc(out_wp_r) != out_rp_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cld_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_data.op)
            cld_pkg::OP_RECV:  state_nxt = (rx_echo_n != 2'd0) ? cld_pkg::ST_ECHO
                                                               : cld_pkg::ST_ACK;
            cld_pkg::OP_WRITE: state_nxt = cld_pkg::ST_ECHO;
            cld_pkg::OP_READ:  state_nxt = rd_go ? cld_pkg::ST_READ : cld_pkg::ST_ACK;
            cld_pkg::OP_POP:   state_nxt = out_empty ? cld_pkg::ST_ACK : cld_pkg::ST_POP;
            default:           state_nxt = cld_pkg::ST_IDLE;
          endcase
        end
      end
      cld_pkg::ST_ECHO: begin
        if (echo_n_r == 2'd1) begin
          state_nxt = cld_pkg::ST_ACK;
        end
      end
      cld_pkg::ST_ACK, cld_pkg::ST_POP: begin
        if (slot_free) begin
          state_nxt = cld_pkg::ST_IDLE;
        end
      end
      cld_pkg::ST_READ: begin
        if (slot_free && rd_stop) begin
          state_nxt = cld_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cld_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    in_wp_nxt     = in_wp_r;
    in_rp_nxt     = in_rp_r;
    lb_nxt        = lb_r;
    bcount_nxt    = bcount_r;
    rlines_nxt    = rlines_r;
    out_wp_nxt    = out_wp_r;
    out_rp_nxt    = out_rp_r;
    echo_q_nxt    = echo_q_r;
    echo_n_nxt    = echo_n_r;
    want_nxt      = want_r;
    n_nxt         = n_r;
    in_wr_en      = 1'b0;
    in_rd_en      = 1'b0;
    in_rd_addr    = in_rp_r;
    out_wr_en     = 1'b0;
    out_rd_en     = 1'b0;
    emit          = 1'b0;
    out_data_nxt  = out_data_r;
    case (state_r)
      cld_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_data.op)
            cld_pkg::OP_RECV: begin
              echo_n_nxt = rx_echo_n;
              if (rx_erase) begin
                echo_q_nxt[0] = cld_pkg::CH_BS;
                echo_q_nxt[1] = cld_pkg::CH_SPACE;
                echo_q_nxt[2] = cld_pkg::CH_BS;
                if (!rx_at_begin) begin
                  in_wp_nxt  = ring_dec(in_wp_r);
                  bcount_nxt = rd_bcount_dec;
                end
              end else if (rx_intr) begin
                echo_q_nxt[0] = cld_pkg::CH_CARET;
                echo_q_nxt[1] = cld_pkg::CH_C;
                echo_q_nxt[2] = cld_pkg::CH_LF;
                in_wp_nxt     = lb_r;
                bcount_nxt    = (bcount_r >= rx_partial) ? bcount_r - rx_partial : '0;
              end else if (rx_room) begin
                echo_q_nxt[0] = rx_c;
                in_wr_en      = 1'b1;
                in_wp_nxt     = ring_inc(in_wp_r);
                bcount_nxt    = bcount_r + PTR_W'(1);
                if (!canon_r || rx_c == cld_pkg::CH_LF) begin
                  if (canon_r) begin
                    lb_nxt = ring_inc(in_wp_r);
                  end
                  if (rlines_r != cld_pkg::LINES_MAX) begin
                    rlines_nxt = rlines_r + 16'd1;
                  end
                end
              end
            end
            cld_pkg::OP_WRITE: begin
              echo_q_nxt[0] = in_data.data_byte;
              echo_n_nxt    = 2'd1;
            end
            cld_pkg::OP_READ: begin
              want_nxt = rd_want;
              n_nxt    = '0;
              if (rd_readable && rd_want != '0 && in_empty && !canon_r) begin
                rlines_nxt = 16'd0;
              end
              in_rd_en = rd_go;
            end
            cld_pkg::OP_POP: begin
              if (!out_empty) begin
                out_rd_en  = 1'b1;
                out_rp_nxt = ring_inc(out_rp_r);
              end
            end
            default: begin
            end
          endcase
        end
      end
      cld_pkg::ST_ECHO: begin
        // each queued byte is pushed only if the output ring has room
        if (out_room) begin
          out_wr_en  = 1'b1;
          out_wp_nxt = ring_inc(out_wp_r);
        end
        echo_q_nxt[0] = echo_q_r[1];
        echo_q_nxt[1] = echo_q_r[2];
        echo_n_nxt    = echo_n_r - 2'd1;
      end
      cld_pkg::ST_ACK: begin
        if (slot_free) begin
          emit         = 1'b1;
          out_data_nxt = '{data_out: 8'd0, data_valid: 1'b0, last: 1'b1};
        end
      end
      cld_pkg::ST_POP: begin
        if (slot_free) begin
          emit         = 1'b1;
          out_data_nxt = '{data_out: out_rdata, data_valid: 1'b1, last: 1'b1};
        end
      end
      cld_pkg::ST_READ: begin
        if (slot_free) begin
          emit         = 1'b1;
          out_data_nxt = '{data_out: in_rdata, data_valid: 1'b1, last: rd_stop};
          in_rp_nxt    = rd_rp_n;
          if (in_rp_r == lb_r) begin
            lb_nxt = rd_rp_n;
          end
          bcount_nxt = rd_bcount_dec;
          n_nxt      = n_r + CNT_W'(1);
          if (rd_stop) begin
            if (canon_r && in_rdata == cld_pkg::CH_LF && rlines_r != 16'd0) begin
              rlines_nxt = rlines_r - 16'd1;
            end
            if (!canon_r && rd_bcount_dec == '0) begin
              rlines_nxt = 16'd0;
            end
          end else begin
            // fetch the next entry while this one goes out
            in_rd_en   = 1'b1;
            in_rd_addr = rd_rp_n;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cld_pkg::ST_IDLE;
      canon_r     <= 1'b1;
      echo_en_r   <= 1'b1;
      in_wp_r     <= '0;
      in_rp_r     <= '0;
      lb_r        <= '0;
      bcount_r    <= '0;
      rlines_r    <= '0;
      out_wp_r    <= '0;
      out_rp_r    <= '0;
      echo_n_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_wp_r     <= in_wp_nxt;
      in_rp_r     <= in_rp_nxt;
      lb_r        <= lb_nxt;
      bcount_r    <= bcount_nxt;
      rlines_r    <= rlines_nxt;
      out_wp_r    <= out_wp_nxt;
      out_rp_r    <= out_rp_nxt;
      echo_n_r    <= echo_n_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          cld_pkg::CFG_CANONICAL: canon_r   <= cfg_data;
          cld_pkg::CFG_ECHO:      echo_en_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    echo_q_r   <= echo_q_nxt;
    want_r     <= want_nxt;
    n_r        <= n_nxt;
    out_data_r <= out_data_nxt;
  end

  cld_ram #(
    .DEPTH  (RING_DEPTH),
    .ADDR_W (PTR_W)
  ) u_in_ram (
    .clk     (clk),
    .wr_en   (in_wr_en),
    .wr_addr (in_wp_r),
    .wr_data (rx_c),
    .rd_en   (in_rd_en),
    .rd_addr (in_rd_addr),
    .rd_data (in_rdata)
  );

  cld_ram #(
    .DEPTH  (RING_DEPTH),
    .ADDR_W (PTR_W)
  ) u_out_ram (
    .clk     (clk),
    .wr_en   (out_wr_en),
    .wr_addr (out_wp_r),
    .wr_data (echo_q_r[0]),
    .rd_en   (out_rd_en),
    .rd_addr (out_rp_r),
    .rd_data (out_rdata)
  );

endmodule
`default_nettype wire
